// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, disabled while reset is low
`define RKH_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("rkh assertion failed");

// antecedent in this cycle, consequent in the next
`define RKH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	`RKH_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

// ----- hdl/rkh_pkg.sv -----
// shared types and constants for the rc4 keyed inner-product hash
// no dependencies
`timescale 1ns / 1ps

package rkh_pkg;

	localparam int WORD_W        = 64;
	localparam int HALF_W        = 32;
	localparam int BYTE_W        = 8;
	localparam int SBOX_DEPTH    = 256;
	localparam int KEY_W         = 128;
	localparam int KIDX_W        = 4;
	localparam int KEY_BYTES_DEF = 16;
	localparam int Q_DEPTH       = 2;
	localparam int CFG_IDX_W     = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_LOW  = 1'b0,
		CFG_KEY_HIGH = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		OP_CONT  = 1'b0,
		OP_REKEY = 1'b1
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              emit;
		logic [WORD_W-1:0] data;
	} item_t;

endpackage

// ----- hdl/rc4_keyed_inner_product_hash_unit.sv -----
// channel  | signals                                  | dir
// ---------+------------------------------------------+-----
// msg      | msg_valid, msg_stall, data_word,         | in
//          | is_first, is_last                        |
// dig      | dig_valid, dig_stall, digest             | out
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// a word is dequeued, s[i] is prefetched, eight rc4 byte steps run (states pj, psw, pwj, pout
// each on the single-read s-box ram), then the split multiply runs in states m0 to m3
// a first word adds a fill of all 256 s-box entries and 256 key steps (krd, kj, ksw, kwj)
// a last word adds a state that loads the digest register; stall on dig holds it there
// a two-item queue takes new items while the back end works; reset clears all control
//
// top level: key registers, front queue and rc4/multiply back end
// depends on rkh_pkg, rkh_front, rkh_back
`timescale 1ns / 1ps

module rc4_keyed_inner_product_hash_unit import rkh_pkg::*; #(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 msg_valid,
	output logic                 msg_stall,
	input  logic [WORD_W-1:0]    data_word,
	input  logic                 is_first,
	input  logic                 is_last,
	output logic                 dig_valid,
	input  logic                 dig_stall,
	output logic [WORD_W-1:0]    digest,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	logic [WORD_W-1:0] key_low_q;
	logic [WORD_W-1:0] key_high_q;
	logic              q_valid;
	logic              q_ready;
	item_t             q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rkh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.data_word (data_word),
		.is_first  (is_first),
		.is_last   (is_last),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item)
	);

	rkh_back #(
		.KEY_BYTES (KEY_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       ({key_high_q, key_low_q}),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.digest    (digest)
	);

endmodule

// ----- hdl/rkh_ram.sv -----
// generic single-write, single-read ram with registered read (old data on collision)
// no dependencies
`timescale 1ns / 1ps

module rkh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/rkh_front.sv -----
// front end: takes message items, tags rekey / emit, holds them in a short queue
// depends on rkh_pkg
`timescale 1ns / 1ps

module rkh_front import rkh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  logic [WORD_W-1:0] data_word,
	input  logic              is_first,
	input  logic              is_last,
	output logic              q_valid,
	input  logic              q_ready,
	output item_t             q_item
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	item_t              ent_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               pop;
	item_t              new_item;

	assign msg_stall = (cnt_q == CNT_W'(Q_DEPTH));
	assign push      = msg_valid && !msg_stall;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_valid && q_ready;
	assign q_item    = ent_q[rd_ptr_q];

	always_comb begin
		new_item.op   = is_first ? OP_REKEY : OP_CONT;
		new_item.emit = is_last;
		new_item.data = data_word;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hdl/rkh_back.sv -----
// back end: rc4 key schedule and keystream over the s-box ram, shared 32x32
// multiplier for the running sum, digest output register
// depends on rkh_pkg and rkh_ram
`timescale 1ns / 1ps

module rkh_back import rkh_pkg::*; #(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [KEY_W-1:0]  key,
	input  logic              q_valid,
	output logic              q_ready,
	input  item_t             q_item,
	output logic              dig_valid,
	input  logic              dig_stall,
	output logic [WORD_W-1:0] digest
);

	localparam int AW = $clog2(SBOX_DEPTH);

	typedef enum logic [15:0] {
		ST_IDLE = 16'b0000_0000_0000_0001,
		ST_FILL = 16'b0000_0000_0000_0010,
		ST_KRD  = 16'b0000_0000_0000_0100,
		ST_KJ   = 16'b0000_0000_0000_1000,
		ST_KSW  = 16'b0000_0000_0001_0000,
		ST_KWJ  = 16'b0000_0000_0010_0000,
		ST_PRD  = 16'b0000_0000_0100_0000,
		ST_PJ   = 16'b0000_0000_1000_0000,
		ST_PSW  = 16'b0000_0001_0000_0000,
		ST_PWJ  = 16'b0000_0010_0000_0000,
		ST_POUT = 16'b0000_0100_0000_0000,
		ST_M0   = 16'b0000_1000_0000_0000,
		ST_M1   = 16'b0001_0000_0000_0000,
		ST_M2   = 16'b0010_0000_0000_0000,
		ST_M3   = 16'b0100_0000_0000_0000,
		ST_EMIT = 16'b1000_0000_0000_0000
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       cnt_q;
	logic [KIDX_W-1:0]   kidx_q;
	logic [2:0]          bcnt_q;
	logic [AW-1:0]       i_q;
	logic [AW-1:0]       j_q;
	logic [BYTE_W-1:0]   si_q;
	logic [BYTE_W-1:0]   sj_q;
	logic                fwd_q;
	logic                last_q;
	logic [WORD_W-1:0]   data_q;
	logic [WORD_W-1:0]   ks_q;
	logic [WORD_W-1:0]   prod_q;
	logic [WORD_W-1:0]   sum_q;
	logic [WORD_W-1:0]   dig_q;
	logic                dig_valid_q;

	logic                we;
	logic [AW-1:0]       waddr;
	logic [BYTE_W-1:0]   wdata;
	logic [AW-1:0]       raddr;
	logic [BYTE_W-1:0]   rdata;

	logic [BYTE_W-1:0]   key_byte;
	logic [AW-1:0]       ksa_j;
	logic [AW-1:0]       prga_j;
	logic [AW-1:0]       out_addr;
	logic [BYTE_W-1:0]   ks_byte;
	logic [HALF_W-1:0]   mul_a;
	logic [HALF_W-1:0]   mul_b;
	logic [WORD_W-1:0]   prod_d;
	logic                dig_free;

	rkh_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (SBOX_DEPTH)
	) u_sbox (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign key_byte = key[{kidx_q, 3'b000} +: BYTE_W];
	assign ksa_j    = j_q + rdata + key_byte;
	assign prga_j   = j_q + rdata;
	assign out_addr = si_q + sj_q;
	assign ks_byte  = fwd_q ? si_q : rdata;
	assign q_ready  = (state_q == ST_IDLE);
	assign dig_free = !dig_valid_q || !dig_stall;
	assign dig_valid = dig_valid_q;
	assign digest    = dig_q;
	assign prod_d    = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

	always_comb begin
		mul_a = ks_q[HALF_W-1:0];
		mul_b = data_q[HALF_W-1:0];
		unique case (state_q)
			ST_M1:   mul_b = data_q[WORD_W-1:HALF_W];
			ST_M2:   mul_a = ks_q[WORD_W-1:HALF_W];
			default: ;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = si_q;
		raddr = cnt_q;
		unique case (state_q)
			ST_FILL: begin
				we    = 1'b1;
				wdata = cnt_q;
			end
			ST_KJ: begin
				raddr = ksa_j;
			end
			ST_KSW: begin
				we    = 1'b1;
				wdata = rdata;
			end
			ST_KWJ: begin
				we    = 1'b1;
				waddr = j_q;
			end
			ST_PRD: begin
				raddr = i_q + 1'b1;
			end
			ST_PJ: begin
				raddr = prga_j;
			end
			ST_PSW: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = rdata;
			end
			ST_PWJ: begin
				we    = 1'b1;
				waddr = j_q;
				raddr = out_addr;
			end
			ST_POUT: begin
				raddr = i_q + 1'b1;
			end
			default: ;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				data_q <= q_item.data;
				last_q <= q_item.emit;
			end
			ST_KJ, ST_PJ: begin
				si_q <= rdata;
			end
			ST_PSW: begin
				sj_q <= rdata;
			end
			ST_PWJ: begin
				fwd_q <= (out_addr == j_q);
			end
			ST_POUT: begin
				ks_q <= {ks_byte, ks_q[WORD_W-1:BYTE_W]};
			end
			ST_M0, ST_M1, ST_M2: begin
				prod_q <= prod_d;
			end
			ST_EMIT: begin
				if (dig_free) begin
					dig_q <= sum_q;
				end
			end
			default: ;
		endcase
	end

	// control and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			kidx_q      <= '0;
			bcnt_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			sum_q       <= '0;
			dig_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && dig_free) begin
				dig_valid_q <= 1'b1;
			end else if (!dig_stall) begin
				dig_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					bcnt_q <= '0;
					if (q_valid) begin
						if (q_item.op == OP_REKEY) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							kidx_q  <= '0;
							j_q     <= '0;
							state_q <= ST_FILL;
						end else begin
							state_q <= ST_PRD;
						end
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == AW'(SBOX_DEPTH - 1)) begin
						state_q <= ST_KRD;
					end
				end
				ST_KRD: begin
					state_q <= ST_KJ;
				end
				ST_KJ: begin
					j_q     <= ksa_j;
					kidx_q  <= (kidx_q == KIDX_W'(KEY_BYTES - 1)) ? '0 : kidx_q + 1'b1;
					state_q <= ST_KSW;
				end
				ST_KSW: begin
					state_q <= ST_KWJ;
				end
				ST_KWJ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == AW'(SBOX_DEPTH - 1)) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_PRD;
					end else begin
						state_q <= ST_KRD;
					end
				end
				ST_PRD: begin
					i_q     <= i_q + 1'b1;
					state_q <= ST_PJ;
				end
				ST_PJ: begin
					j_q     <= prga_j;
					state_q <= ST_PSW;
				end
				ST_PSW: begin
					state_q <= ST_PWJ;
				end
				ST_PWJ: begin
					state_q <= ST_POUT;
				end
				ST_POUT: begin
					if (bcnt_q == 3'd7) begin
						state_q <= ST_M0;
					end else begin
						bcnt_q  <= bcnt_q + 1'b1;
						i_q     <= i_q + 1'b1;
						state_q <= ST_PJ;
					end
				end
				ST_M0: begin
					state_q <= ST_M1;
				end
				ST_M1: begin
					sum_q   <= sum_q + prod_q;
					state_q <= ST_M2;
				end
				ST_M2: begin
					sum_q   <= sum_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
					state_q <= ST_M3;
				end
				ST_M3: begin
					sum_q   <= sum_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (dig_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/rkh_checker.sv -----
// port-level checks for the hash unit, bound to the top level
// depends on rkh_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rkh_checker import rkh_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              msg_valid,
	input logic              msg_stall,
	input logic              is_last,
	input logic              dig_valid,
	input logic              dig_stall,
	input logic [WORD_W-1:0] digest
);

	logic [2:0] pend_q;
	logic       last_in;
	logic       dig_out;

	assign last_in = msg_valid && !msg_stall && is_last;
	assign dig_out = dig_valid && !dig_stall;

	// digests owed: last items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({last_in, dig_out})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	`RKH_ASSERT_NEXT(a_dig_hold, clk, arst_n, dig_valid && dig_stall, dig_valid)
	`RKH_ASSERT_NEXT(a_dig_stable, clk, arst_n, dig_valid && dig_stall, $stable(digest))
	`RKH_ASSERT(a_dig_owed, clk, arst_n, dig_valid |-> pend_q != 3'd0)
	`RKH_ASSERT(a_pend_bound, clk, arst_n, pend_q <= 3'd4)

endmodule

bind rc4_keyed_inner_product_hash_unit rkh_checker u_rkh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_valid (msg_valid),
	.msg_stall (msg_stall),
	.is_last   (is_last),
	.dig_valid (dig_valid),
	.dig_stall (dig_stall),
	.digest    (digest)
);
